>>> design/tsp_pkg.sv
// Shared types, request codes and helpers for the tone sequence player.
package tsp_pkg;

  localparam int FREQ_W = 11;
  localparam int DUR_W  = 16;
  localparam int IDX_W  = 8;
  localparam int GAP_W  = 8;
  localparam logic [GAP_W-1:0] GAP_RESET = 8'd20;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_WRITE = 2'd3
  } req_e_t;

  // Store entry: frequency in the low bits, duration above it.
  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  typedef struct packed {
    req_e_t            kind;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } req_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_hz;
    logic              led_on;
    logic              playing;
    logic              finished;
  } result_t;

  function automatic logic is_end(input entry_t e);
    return (e.freq == '0) && (e.dur == '0);
  endfunction

endpackage

>>> design/tsp_note_store.sv
// Note store memory: one write port, two registered read ports.
module tsp_note_store #(
  parameter int STORE_DEPTH = 256,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tsp_pkg::entry_t wr_data,
  input  logic            rda_en,
  input  logic [AW-1:0]   rda_addr,
  output tsp_pkg::entry_t rda_data,
  input  logic            rdb_en,
  input  logic [AW-1:0]   rdb_addr,
  output tsp_pkg::entry_t rdb_data
);

  tsp_pkg::entry_t mem [STORE_DEPTH];
  tsp_pkg::entry_t rda_r;
  tsp_pkg::entry_t rdb_r;

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      rda_r <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_r <= mem[rdb_addr];
    end
  end

  assign rda_data = rda_r;
  assign rdb_data = rdb_r;

endmodule

>>> design/tsp_play_ctrl.sv
// Playback state and per-word update logic: pointer, elapsed count, gap, tone.
module tsp_play_ctrl #(
  parameter int STORE_DEPTH = 256,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       proc,
  input  tsp_pkg::req_t              req,
  input  logic [AW-1:0]              req_addr,
  input  logic [tsp_pkg::GAP_W-1:0]  gap_ms,
  input  tsp_pkg::entry_t            start_entry,
  input  tsp_pkg::entry_t            refill_data,
  output logic                       refill_en,
  output logic [AW-1:0]              refill_addr,
  output tsp_pkg::result_t           result
);

  logic                        active_r, active_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [tsp_pkg::DUR_W-1:0]   elapsed_r, elapsed_nxt;
  logic                        gap_r, gap_nxt;
  logic [tsp_pkg::FREQ_W-1:0]  tone_r, tone_nxt;
  tsp_pkg::entry_t             cur_r, cur_nxt;
  tsp_pkg::entry_t             ahead_r, ahead_nxt;
  logic                        ahead_pend_r;
  tsp_pkg::entry_t             ahead_eff;
  logic [AW-1:0]               ptr_inc;
  logic [tsp_pkg::DUR_W-1:0]   e_inc;
  logic [tsp_pkg::DUR_W-1:0]   gap_w;
  logic                        fin;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(STORE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // Entry after the pointer arrives from memory in the cycle after a refill read.
  assign ahead_eff = ahead_pend_r ? refill_data : ahead_r;
  assign ptr_inc   = wrap_inc(ptr_r);
  assign e_inc     = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign gap_w     = tsp_pkg::DUR_W'(gap_ms);

  always_comb begin
    active_nxt  = active_r;
    ptr_nxt     = ptr_r;
    elapsed_nxt = elapsed_r;
    gap_nxt     = gap_r;
    tone_nxt    = tone_r;
    cur_nxt     = cur_r;
    ahead_nxt   = ahead_eff;
    fin         = 1'b0;
    refill_en   = 1'b0;
    refill_addr = wrap_inc(req_addr);
    case (req.kind)
      tsp_pkg::REQ_WRITE: begin
        // keep cached entries coherent with the store
        if (req_addr == ptr_r) begin
          cur_nxt = {req.dur, req.freq};
        end
        if (req_addr == ptr_inc) begin
          ahead_nxt = {req.dur, req.freq};
        end
      end
      tsp_pkg::REQ_START: begin
        active_nxt  = 1'b1;
        ptr_nxt     = req_addr;
        elapsed_nxt = '0;
        gap_nxt     = 1'b0;
        cur_nxt     = start_entry;
        tone_nxt    = tsp_pkg::is_end(start_entry) ? '0 : start_entry.freq;
        refill_en   = 1'b1;
        refill_addr = wrap_inc(req_addr);
      end
      tsp_pkg::REQ_STOP: begin
        active_nxt = 1'b0;
        tone_nxt   = '0;
      end
      tsp_pkg::REQ_TICK: begin
        if (active_r) begin
          if (tsp_pkg::is_end(cur_r)) begin
            active_nxt = 1'b0;
            tone_nxt   = '0;
            fin        = 1'b1;
          end else if (e_inc >= cur_r.dur) begin
            // advance to the next entry
            ptr_nxt     = ptr_inc;
            elapsed_nxt = '0;
            gap_nxt     = 1'b0;
            cur_nxt     = ahead_eff;
            refill_en   = 1'b1;
            refill_addr = wrap_inc(ptr_inc);
            if (tsp_pkg::is_end(ahead_eff)) begin
              active_nxt = 1'b0;
              tone_nxt   = '0;
              fin        = 1'b1;
            end else begin
              tone_nxt = ahead_eff.freq;
            end
          end else begin
            elapsed_nxt = e_inc;
            if (!gap_r && (cur_r.dur >= gap_w) && (e_inc >= cur_r.dur - gap_w)) begin
              gap_nxt  = 1'b1;
              tone_nxt = '0;
            end
          end
        end
      end
      default: begin
        active_nxt = active_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      ptr_r        <= '0;
      elapsed_r    <= '0;
      gap_r        <= 1'b0;
      tone_r       <= '0;
      ahead_pend_r <= 1'b0;
    end else begin
      ahead_pend_r <= proc && refill_en;
      if (proc) begin
        active_r  <= active_nxt;
        ptr_r     <= ptr_nxt;
        elapsed_r <= elapsed_nxt;
        gap_r     <= gap_nxt;
        tone_r    <= tone_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      cur_r   <= cur_nxt;
      ahead_r <= ahead_nxt;
    end else if (ahead_pend_r) begin
      ahead_r <= refill_data;
    end
  end

  assign result.tone_hz  = tone_nxt;
  assign result.led_on   = (tone_nxt != '0);
  assign result.playing  = active_nxt;
  assign result.finished = fin;

endmodule

>>> design/tone_sequence_player_unit.sv
// Top level of the tone sequence player: handshakes, config register, store, control.
//
//   channel  direction  handshake          payload
//   in_      word in    in_valid/in_stall  req_type, entry_index, entry_freq, entry_dur
//   out_     word out   out_valid/out_stall tone_hz, led_on, playing, finished
//   cfg_     write      cfg_wr_en          cfg_wr_data -> gap_ms
//
// One word per cycle sustained while out_stall is low; each word is registered in s1, then in the result register.
// Start reads the store at accept; the entry after the pointer is refetched on
// the second read port whenever the pointer moves, and cached between moves.
// Reset is synchronous; the note store is not cleared and needs no sweep.
// A stalled result holds; the input stage keeps going while the result register drains.
module tone_sequence_player_unit #(
  parameter int STORE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [tsp_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [tsp_pkg::FREQ_W-1:0]  in_entry_freq,
  input  logic [tsp_pkg::DUR_W-1:0]   in_entry_dur,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsp_pkg::FREQ_W-1:0]  out_tone_hz,
  output logic                        out_led_on,
  output logic                        out_playing,
  output logic                        out_finished,
  input  logic                        cfg_wr_en,
  input  logic [tsp_pkg::GAP_W-1:0]   cfg_wr_data
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int IDX_NUM = 2 ** tsp_pkg::IDX_W;

  logic                       gap_we;
  logic [tsp_pkg::GAP_W-1:0]  gap_ms_r;
  logic                       s1_valid_r;
  tsp_pkg::req_t              s1_req_r;
  logic [AW-1:0]              s1_addr_r;
  logic                       out_valid_r;
  tsp_pkg::result_t           out_r;
  logic [AW-1:0]              idx_mod [IDX_NUM];
  logic [AW-1:0]              in_addr;
  logic                       in_acc;
  logic                       s1_adv;
  logic                       proc;
  tsp_pkg::req_e_t            in_kind;
  tsp_pkg::entry_t            start_entry;
  tsp_pkg::entry_t            refill_data;
  logic                       refill_en;
  logic [AW-1:0]              refill_addr;
  tsp_pkg::result_t           result;

  // Constant table: entry index modulo store depth.
  for (genvar g = 0; g < IDX_NUM; g++) begin : g_mod
    assign idx_mod[g] = AW'(g % STORE_DEPTH);
  end

  assign in_addr  = idx_mod[in_entry_index];
  assign in_kind  = tsp_pkg::req_e_t'(in_req_type);
  assign s1_adv   = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign gap_we   = cfg_wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ms_r <= tsp_pkg::GAP_RESET;
    end else if (gap_we) begin
      gap_ms_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= '{kind: in_kind, freq: in_entry_freq, dur: in_entry_dur};
      s1_addr_r <= in_addr;
    end
    if (proc) begin
      out_r <= result;
    end
  end

  tsp_note_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (in_acc && (in_kind == tsp_pkg::REQ_WRITE)),
    .wr_addr  (in_addr),
    .wr_data  ({in_entry_dur, in_entry_freq}),
    .rda_en   (in_acc),
    .rda_addr (in_addr),
    .rda_data (start_entry),
    .rdb_en   (proc && refill_en),
    .rdb_addr (refill_addr),
    .rdb_data (refill_data)
  );

  tsp_play_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .req         (s1_req_r),
    .req_addr    (s1_addr_r),
    .gap_ms      (gap_ms_r),
    .start_entry (start_entry),
    .refill_data (refill_data),
    .refill_en   (refill_en),
    .refill_addr (refill_addr),
    .result      (result)
  );

  assign out_valid    = out_valid_r;
  assign out_tone_hz  = out_r.tone_hz;
  assign out_led_on   = out_r.led_on;
  assign out_playing  = out_r.playing;
  assign out_finished = out_r.finished;

  a_fin_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_playing)
    else $error("finished with playback still active");

  a_led_tracks_tone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_on == (out_tone_hz != '0)))
    else $error("led does not follow tone");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_fin_drops_play: assert property (@(posedge clk) disable iff (!rst_n)
    proc && result.finished |=> !u_ctrl.active_r)
    else $error("playback active after finish");

endmodule

>>> dv/tsp_player_checker.sv
// Checker for the tone sequence player: predicts each result word and compares it.
`timescale 1ns / 100ps

module tsp_player_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [tsp_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [tsp_pkg::FREQ_W-1:0] in_entry_freq,
  input  logic [tsp_pkg::DUR_W-1:0]  in_entry_dur,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [tsp_pkg::FREQ_W-1:0] out_tone_hz,
  input  logic                       out_led_on,
  input  logic                       out_playing,
  input  logic                       out_finished,
  input  logic                       cfg_wr_en,
  input  logic [tsp_pkg::GAP_W-1:0]  cfg_wr_data,
  output int                         fail_count,
  output int                         due_count,
  output int                         words_checked,
  output int                         ends_seen
);

  tsp_pkg::entry_t            notes [256];
  logic [tsp_pkg::GAP_W-1:0]  gap_len;
  logic                       seq_active;
  logic [tsp_pkg::IDX_W-1:0]  note_ptr;
  logic [tsp_pkg::DUR_W-1:0]  ms_count;
  logic                       gap_on;
  logic [tsp_pkg::FREQ_W-1:0] tone_out;
  tsp_pkg::result_t           tone_due [$];

  function automatic logic marker_at(input logic [tsp_pkg::IDX_W-1:0] p);
    return (notes[p].freq == '0) && (notes[p].dur == '0);
  endfunction

  // Advance the player by one request and return the word it shows afterwards.
  task automatic play_word(input tsp_pkg::req_e_t kind,
                           input logic [tsp_pkg::IDX_W-1:0] idx,
                           input logic [tsp_pkg::FREQ_W-1:0] frq,
                           input logic [tsp_pkg::DUR_W-1:0] len_in,
                           output tsp_pkg::result_t word);
    logic                      done;
    logic [tsp_pkg::DUR_W-1:0] len;
    done = 1'b0;
    case (kind)
      tsp_pkg::REQ_WRITE: begin
        notes[idx].freq = frq;
        notes[idx].dur  = len_in;
      end
      tsp_pkg::REQ_START: begin
        seq_active = 1'b1;
        note_ptr   = idx;
        ms_count   = '0;
        gap_on     = 1'b0;
        tone_out   = marker_at(idx) ? '0 : notes[idx].freq;
      end
      tsp_pkg::REQ_STOP: begin
        seq_active = 1'b0;
        tone_out   = '0;
      end
      default: begin
        if (seq_active) begin
          if (marker_at(note_ptr)) begin
            seq_active = 1'b0;
            tone_out   = '0;
            done       = 1'b1;
          end else begin
            len = notes[note_ptr].dur;
            if (ms_count != '1) ms_count = ms_count + 1'b1;
            if (ms_count >= len) begin
              note_ptr = note_ptr + 1'b1;
              ms_count = '0;
              gap_on   = 1'b0;
              if (marker_at(note_ptr)) begin
                seq_active = 1'b0;
                tone_out   = '0;
                done       = 1'b1;
              end else begin
                tone_out = notes[note_ptr].freq;
              end
            end else if (!gap_on && len >= {8'd0, gap_len} &&
                         ms_count >= len - {8'd0, gap_len}) begin
              gap_on   = 1'b1;
              tone_out = '0;
            end
          end
        end
      end
    endcase
    word.tone_hz  = tone_out;
    word.led_on   = (tone_out != '0);
    word.playing  = seq_active;
    word.finished = done;
  endtask

  always @(posedge clk) begin : watch
    tsp_pkg::result_t want;
    tsp_pkg::result_t got;
    tsp_pkg::result_t next_word;
    if (!rst_n) begin
      gap_len       = tsp_pkg::GAP_RESET;
      seq_active    = 1'b0;
      note_ptr      = '0;
      ms_count      = '0;
      gap_on        = 1'b0;
      tone_out      = '0;
      fail_count    = 0;
      words_checked = 0;
      ends_seen     = 0;
      tone_due.delete();
    end else begin
      // Check the leaving word before booking the arriving one.
      if (out_valid && !out_stall) begin
        got.tone_hz  = out_tone_hz;
        got.led_on   = out_led_on;
        got.playing  = out_playing;
        got.finished = out_finished;
        if (tone_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"[%0t] unexpected word: tone_hz %0d led_on %0b playing %0b ",
                      "finished %0b"},
                     $realtime, got.tone_hz, got.led_on, got.playing, got.finished);
        end else begin
          want = tone_due.pop_front();
          words_checked++;
          if (got.finished) ends_seen++;
          if (got.tone_hz !== want.tone_hz || got.led_on !== want.led_on ||
              got.playing !== want.playing || got.finished !== want.finished) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] word %0d mismatch: tone_hz exp %0d got %0d, led_on exp %0b ",
                        "got %0b, playing exp %0b got %0b, finished exp %0b got %0b"},
                       $realtime, words_checked, want.tone_hz, got.tone_hz, want.led_on,
                       got.led_on, want.playing, got.playing, want.finished, got.finished);
          end
        end
      end
      if (cfg_wr_en) gap_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        play_word(tsp_pkg::req_e_t'(in_req_type), in_entry_index, in_entry_freq,
                  in_entry_dur, next_word);
        tone_due.push_back(next_word);
      end
    end
    due_count = tone_due.size();
  end

endmodule

>>> dv/tb_top.sv
// Testbench top for the tone sequence player: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int WORD_TARGET = 1550;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 6;

  typedef enum {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_TOGGLE} drain_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 in_req_type;
  logic [tsp_pkg::IDX_W-1:0]  in_entry_index;
  logic [tsp_pkg::FREQ_W-1:0] in_entry_freq;
  logic [tsp_pkg::DUR_W-1:0]  in_entry_dur;
  logic                       out_valid;
  logic                       out_stall;
  logic [tsp_pkg::FREQ_W-1:0] out_tone_hz;
  logic                       out_led_on;
  logic                       out_playing;
  logic                       out_finished;
  logic                       cfg_wr_en;
  logic [tsp_pkg::GAP_W-1:0]  cfg_wr_data;

  int fail_count;
  int due_count;
  int words_checked;
  int ends_seen;

  int words_sent;
  int burst_left;
  bit steady;
  int hold_asks;

  tone_sequence_player_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_freq  (in_entry_freq),
    .in_entry_dur   (in_entry_dur),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tone_hz    (out_tone_hz),
    .out_led_on     (out_led_on),
    .out_playing    (out_playing),
    .out_finished   (out_finished),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  tsp_player_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_entry_freq  (in_entry_freq),
    .in_entry_dur   (in_entry_dur),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tone_hz    (out_tone_hz),
    .out_led_on     (out_led_on),
    .out_playing    (out_playing),
    .out_finished   (out_finished),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .due_count      (due_count),
    .words_checked  (words_checked),
    .ends_seen      (ends_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: stall on a changing pattern, or hold off entirely on request.
  initial begin : receiver
    drain_mode_t mode;
    int          mode_left;
    int          hold_done;
    out_stall = 1'b0;
    mode      = DRAIN_FREE;
    mode_left = 40;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          DRAIN_FREE:  out_stall <= 1'b0;
          DRAIN_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          DRAIN_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Offer one word and hold it until accepted; bursts end in random gaps unless steady is set.
  task automatic put_word(input tsp_pkg::req_e_t kind,
                          input logic [tsp_pkg::IDX_W-1:0] idx,
                          input logic [tsp_pkg::FREQ_W-1:0] frq,
                          input logic [tsp_pkg::DUR_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_entry_index <= idx;
    in_entry_freq  <= frq;
    in_entry_dur   <= len;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put_noise_tick();
    put_word(tsp_pkg::REQ_TICK, tsp_pkg::IDX_W'($urandom), tsp_pkg::FREQ_W'($urandom),
             tsp_pkg::DUR_W'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_gap(input logic [tsp_pkg::GAP_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly short notes, with end markers, rests, zero-length and long notes mixed in.
  function automatic tsp_pkg::entry_t pick_note();
    tsp_pkg::entry_t e;
    int              r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      e.freq = '0;
      e.dur  = '0;
    end else if (r < 28) begin
      e.freq = '0;
      e.dur  = tsp_pkg::DUR_W'($urandom_range(1, 30));
    end else if (r < 33) begin
      e.freq = tsp_pkg::FREQ_W'($urandom_range(1, 2047));
      e.dur  = '0;
    end else if (r < 36) begin
      e.freq = tsp_pkg::FREQ_W'($urandom_range(1, 2047));
      e.dur  = tsp_pkg::DUR_W'($urandom);
    end else begin
      e.freq = tsp_pkg::FREQ_W'($urandom_range(1, 2047));
      e.dur  = tsp_pkg::DUR_W'($urandom_range(1, 40));
    end
    return e;
  endfunction

  task automatic put_note(input logic [tsp_pkg::IDX_W-1:0] idx, input tsp_pkg::entry_t e);
    put_word(tsp_pkg::REQ_WRITE, idx, e.freq, e.dur);
  endtask

  task automatic run_directed();
    set_gap(8'd1);
    // Tone with gap, rest, zero-length note, end marker.
    put_word(tsp_pkg::REQ_WRITE, 8'd10, 11'h7FF, 16'd2);
    put_word(tsp_pkg::REQ_WRITE, 8'd11, 11'd0, 16'd1);
    put_word(tsp_pkg::REQ_WRITE, 8'd12, 11'd1, 16'd0);
    put_word(tsp_pkg::REQ_WRITE, 8'd13, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_START, 8'd10, 11'd0, 16'd0);
    repeat (5) put_word(tsp_pkg::REQ_TICK, 8'hFF, 11'h7FF, 16'hFFFF);
    // Start right on an end marker.
    put_word(tsp_pkg::REQ_START, 8'd13, 11'h7FF, 16'hFFFF);
    put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    // Pointer wraps from the top address to the bottom.
    put_word(tsp_pkg::REQ_WRITE, 8'd255, 11'd100, 16'd1);
    put_word(tsp_pkg::REQ_WRITE, 8'd0, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_START, 8'd255, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    // Gap longer than the note: no silence.
    set_gap(8'd255);
    put_word(tsp_pkg::REQ_WRITE, 8'd20, 11'd500, 16'd2);
    put_word(tsp_pkg::REQ_WRITE, 8'd21, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_START, 8'd20, 11'd0, 16'd0);
    repeat (2) put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    // Gap equal to the note: silent from the first tick, then stop.
    set_gap(8'd20);
    put_word(tsp_pkg::REQ_WRITE, 8'd30, 11'd7, 16'd20);
    put_word(tsp_pkg::REQ_START, 8'd30, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_STOP, 8'hFF, 11'h7FF, 16'hFFFF);
    // Longest note, then overwrite the playing entry with an end marker.
    put_word(tsp_pkg::REQ_WRITE, 8'd40, 11'd1234, 16'hFFFF);
    put_word(tsp_pkg::REQ_START, 8'd40, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_WRITE, 8'd40, 11'd0, 16'd0);
    put_word(tsp_pkg::REQ_TICK, 8'd0, 11'd0, 16'd0);
    set_gap(8'd0);
  endtask

  // Block fills while the result side holds off.
  task automatic run_pressure();
    hold_asks++;
    steady     = 1'b1;
    burst_left = 0;
    put_word(tsp_pkg::REQ_START, tsp_pkg::IDX_W'($urandom), tsp_pkg::FREQ_W'($urandom),
             tsp_pkg::DUR_W'($urandom));
    repeat (40) put_noise_tick();
    steady = 1'b0;
  endtask

  task automatic run_phase();
    int pick;
    int ticks;
    steady = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(3, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        put_word(tsp_pkg::req_e_t'($urandom_range(0, 3)), tsp_pkg::IDX_W'($urandom),
                 tsp_pkg::FREQ_W'($urandom), tsp_pkg::DUR_W'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) put_note(tsp_pkg::IDX_W'($urandom), pick_note());
        put_word(tsp_pkg::REQ_START, tsp_pkg::IDX_W'($urandom), tsp_pkg::FREQ_W'($urandom),
                 tsp_pkg::DUR_W'($urandom));
        ticks = $urandom_range(1, 60);
        repeat (ticks) begin
          pick = $urandom_range(0, 99);
          if (pick < 4)
            put_note(tsp_pkg::IDX_W'($urandom), pick_note());
          else if (pick < 6)
            put_word(tsp_pkg::REQ_STOP, tsp_pkg::IDX_W'($urandom),
                     tsp_pkg::FREQ_W'($urandom), tsp_pkg::DUR_W'($urandom));
          else
            put_noise_tick();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    int                        phase;
    logic [tsp_pkg::GAP_W-1:0] g;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = tsp_pkg::REQ_TICK;
    in_entry_index = '0;
    in_entry_freq  = '0;
    in_entry_dur   = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    words_sent     = 0;
    burst_left     = 0;
    steady         = 1'b0;
    hold_asks      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load every address so no playback ever reads an unwritten entry.
    for (int a = 0; a < 256; a++) put_note(tsp_pkg::IDX_W'(a), pick_note());

    run_directed();
    run_pressure();

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      if (phase % 3 == 0) begin
        case ($urandom_range(0, 4))
          0:       g = 8'd0;
          1:       g = 8'd255;
          2:       g = tsp_pkg::GAP_RESET;
          3:       g = tsp_pkg::GAP_W'($urandom_range(0, 40));
          default: g = tsp_pkg::GAP_W'($urandom);
        endcase
        set_gap(g);
      end
      if ($urandom_range(0, 5) == 0) run_pressure();
      run_phase();
      phase++;
    end

    wait_idle();
    repeat (10) @(negedge clk);

    $display("Covered %0d request words over %0d phases: %0d results checked, %0d ends.",
             words_sent, phase, words_checked, ends_seen);
    $display("Gap settings 0, 20, 255 and random; result side held off and stalled at random.");
    if (fail_count == 0 && due_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
